FILE: rtl/rrb_pkg.sv
// Shared types and constants for the relative range/bearing block.
// No dependencies.
package rrb_pkg;

  localparam int CORD_W       = 40;  // signed CORDIC operand width
  localparam int CORDIC_STEPS = 28;

  localparam logic [31:0] QUARTER_TURN = 32'h4000_0000;
  localparam logic [31:0] HALF_TURN    = 32'h8000_0000;

  // One pose request as it sits in the queue.
  typedef struct packed {
    logic        sel;
    logic [31:0] pos_x;
    logic [31:0] pos_y;
    logic [15:0] qx;
    logic [15:0] qy;
    logic [15:0] qz;
    logic [15:0] qw;
    logic [31:0] stamp;
  } pose_t;

  // arctan(2^-i) as a binary angle, 2^32 per turn
  function automatic logic [29:0] atan_entry(input logic [4:0] i);
    logic [29:0] r;
    case (i)
      5'd0:  r = 30'd536870912;
      5'd1:  r = 30'd316933406;
      5'd2:  r = 30'd167458907;
      5'd3:  r = 30'd85004756;
      5'd4:  r = 30'd42667331;
      5'd5:  r = 30'd21354465;
      5'd6:  r = 30'd10679838;
      5'd7:  r = 30'd5340245;
      5'd8:  r = 30'd2670163;
      5'd9:  r = 30'd1335087;
      5'd10: r = 30'd667544;
      5'd11: r = 30'd333772;
      5'd12: r = 30'd166886;
      5'd13: r = 30'd83443;
      5'd14: r = 30'd41722;
      5'd15: r = 30'd20861;
      5'd16: r = 30'd10430;
      5'd17: r = 30'd5215;
      5'd18: r = 30'd2608;
      5'd19: r = 30'd1304;
      5'd20: r = 30'd652;
      5'd21: r = 30'd326;
      5'd22: r = 30'd163;
      5'd23: r = 30'd81;
      5'd24: r = 30'd41;
      5'd25: r = 30'd20;
      5'd26: r = 30'd10;
      5'd27: r = 30'd5;
      default: r = 30'd0;
    endcase
    return r;
  endfunction

endpackage

FILE: rtl/rrb_queue.sv
// Two-entry request queue between the input port and the back end.
// Depends on rrb_pkg.
module rrb_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  rrb_pkg::pose_t in_data_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output rrb_pkg::pose_t out_data_o
);
  import rrb_pkg::*;

  pose_t      mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;
  logic       push, pop;

  assign in_ready_o  = (cnt_q != 2'd2);
  assign out_valid_o = (cnt_q != 2'd0);
  assign out_data_o  = mem_q[rd_ptr_q];
  assign push        = in_valid_i && in_ready_o;
  assign pop         = out_valid_o && out_ready_i;

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_ptr_q] <= in_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (pop)  rd_ptr_q <= ~rd_ptr_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

FILE: rtl/rrb_cordic.sv
// Iterative vectoring CORDIC: atan2(y,x) as a binary angle (2^32 per turn).
// Depends on rrb_pkg.
module rrb_cordic (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  input  logic signed [rrb_pkg::CORD_W-1:0]   x_i,
  input  logic signed [rrb_pkg::CORD_W-1:0]   y_i,
  output logic                                busy_o,
  output logic [31:0]                         turn_o
);
  import rrb_pkg::*;

  localparam logic [1:0] C_IDLE = 2'd0;
  localparam logic [1:0] C_NORM = 2'd1;
  localparam logic [1:0] C_ITER = 2'd2;
  localparam logic [1:0] C_FIN  = 2'd3;

  logic [1:0]         st_q;
  logic [59:0]        ax_q, ay_q, m_q;
  logic               xneg_q, yneg_q;
  logic signed [61:0] cx_q, cy_q;
  logic signed [33:0] z_q;
  logic [4:0]         i_q;
  logic [31:0]        turn_q;

  logic [CORD_W-1:0]  ax_c, ay_c;
  logic [4:0]         sh_c;
  logic signed [61:0] sx_c, sy_c;
  logic signed [33:0] at_c, zc_c;
  logic [31:0]        q_c;

  assign busy_o = (st_q != C_IDLE);
  assign turn_o = turn_q;

  always_comb begin
    ax_c = x_i[CORD_W-1] ? CORD_W'(-x_i) : CORD_W'(x_i);
    ay_c = y_i[CORD_W-1] ? CORD_W'(-y_i) : CORD_W'(y_i);
    // coarse normalize: keep max magnitude below 2^59
    if (m_q[58:43] == 16'd0)     sh_c = 5'd16;
    else if (m_q[58:51] == 8'd0) sh_c = 5'd8;
    else if (m_q[58:55] == 4'd0) sh_c = 5'd4;
    else                         sh_c = 5'd1;
    sx_c = cx_q >>> i_q;
    sy_c = cy_q >>> i_q;
    at_c = 34'(atan_entry(i_q));
    if (z_q < 0)                             zc_c = '0;
    else if (z_q > $signed({2'b00, QUARTER_TURN})) zc_c = $signed({2'b00, QUARTER_TURN});
    else                                     zc_c = z_q;
    q_c = zc_c[31:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= C_IDLE;
      i_q  <= '0;
    end else begin
      case (st_q)
        C_IDLE: if (start_i) st_q <= C_NORM;
        C_NORM: begin
          if (ay_q == '0 || ax_q == '0) st_q <= C_FIN;
          else if (!m_q[58]) st_q <= C_NORM;
          else begin
            st_q <= C_ITER;
            i_q  <= '0;
          end
        end
        C_ITER: begin
          if (i_q == 5'(CORDIC_STEPS - 1)) st_q <= C_FIN;
          i_q <= i_q + 5'd1;
        end
        C_FIN:   st_q <= C_IDLE;
        default: st_q <= C_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (st_q)
      C_IDLE: begin
        ax_q   <= 60'(ax_c);
        ay_q   <= 60'(ay_c);
        m_q    <= (ax_c > ay_c) ? 60'(ax_c) : 60'(ay_c);
        xneg_q <= x_i[CORD_W-1];
        yneg_q <= y_i[CORD_W-1];
        z_q    <= '0;
      end
      C_NORM: begin
        if (ay_q == '0) z_q <= '0;
        else if (ax_q == '0) z_q <= $signed({2'b00, QUARTER_TURN});
        else if (!m_q[58]) begin
          ax_q <= ax_q << sh_c;
          ay_q <= ay_q << sh_c;
          m_q  <= m_q << sh_c;
        end else begin
          cx_q <= $signed({2'b00, ax_q});
          cy_q <= $signed({2'b00, ay_q});
        end
      end
      C_ITER: begin
        if (!cy_q[61]) begin
          cx_q <= cx_q + sy_c;
          cy_q <= cy_q - sx_c;
          z_q  <= z_q + at_c;
        end else begin
          cx_q <= cx_q - sy_c;
          cy_q <= cy_q + sx_c;
          z_q  <= z_q - at_c;
        end
      end
      C_FIN: begin
        if (!xneg_q && !yneg_q)     turn_q <= q_c;
        else if (xneg_q && !yneg_q) turn_q <= HALF_TURN - q_c;
        else if (xneg_q)            turn_q <= HALF_TURN + q_c;
        else                        turn_q <= 32'd0 - q_c;
      end
      default: ;
    endcase
  end

endmodule

FILE: rtl/rrb_back.sv
// Back end: yaw from quaternion, pose store, range square root, bearing.
// Depends on rrb_pkg and rrb_cordic.
module rrb_back #(
  parameter int ANGLE_FRAC_BITS = 16
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           req_valid_i,
  output logic           req_ready_o,
  input  rrb_pkg::pose_t req_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output logic [32:0]    range_out_o,
  output logic [24:0]    bearing_out_o,
  output logic [24:0]    heading_diff_o,
  output logic [31:0]    stamp_out_o
);
  import rrb_pkg::*;

  localparam int DW = 9 + ANGLE_FRAC_BITS;
  localparam int SH = 32 - ANGLE_FRAC_BITS;
  localparam logic [DW:0] FC  = (DW+1)'(360) << ANGLE_FRAC_BITS;
  localparam logic [41:0] RND = 42'd1 << (31 - ANGLE_FRAC_BITS);

  localparam logic [3:0] B_IDLE  = 4'd0;
  localparam logic [3:0] B_PROD  = 4'd1;
  localparam logic [3:0] B_SUM   = 4'd2;
  localparam logic [3:0] B_GLO   = 4'd3;
  localparam logic [3:0] B_GHI   = 4'd4;
  localparam logic [3:0] B_YWAIT = 4'd5;
  localparam logic [3:0] B_YMUL  = 4'd6;
  localparam logic [3:0] B_YWRAP = 4'd7;
  localparam logic [3:0] B_DIFF  = 4'd8;
  localparam logic [3:0] B_SQX   = 4'd9;
  localparam logic [3:0] B_SQY   = 4'd10;
  localparam logic [3:0] B_RWAIT = 4'd11;
  localparam logic [3:0] B_BMUL  = 4'd12;
  localparam logic [3:0] B_OUT   = 4'd13;

  logic [3:0]          st_q;
  pose_t               cur_q;
  logic [2:0]          pidx_q;
  logic signed [31:0]  prod_q [8];
  logic signed [35:0]  norm_q, num_q, gx_q, gy_q;
  logic signed [53:0]  lhs_q;
  logic                gimb_q;
  logic [40:0]         dmul_q;
  logic [DW-1:0]       yaw_q, atd_q;
  logic [31:0]         fx_q, fy_q, fst_q, sx_q, sy_q, sst_q;
  logic [DW-1:0]       fyaw_q, syaw_q;
  logic signed [32:0]  dx_q, dy_q;
  logic [64:0]         acc_q;
  logic [65:0]         rad_q;
  logic [35:0]         rem_q;
  logic [33:0]         root_q;
  logic [5:0]          sq_cnt_q;
  logic                out_valid_q;
  logic [32:0]         range_q;
  logic [DW-1:0]       bear_q, hdiff_q;
  logic [31:0]         ostamp_q;

  logic                cord_start;
  logic signed [CORD_W-1:0] cord_x, cord_y;
  logic                cord_busy;
  logic [31:0]         cord_turn;

  logic signed [15:0]  pa_c, pb_c;
  logic signed [53:0]  rhs_c;
  logic                glo_c, ghi_c;
  logic [41:0]         dsum_c;
  logic [DW:0]         dsh_c, deg_w_c;
  logic [DW-1:0]       deg_c;
  logic [31:0]         ux_c, uy_c;
  logic [35:0]         rem_sh_c, trial_c;
  logic [DW:0]         bsum_c, hsum_c;
  logic                out_load;

  rrb_cordic u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cord_start),
    .x_i     (cord_x),
    .y_i     (cord_y),
    .busy_o  (cord_busy),
    .turn_o  (cord_turn)
  );

  assign req_ready_o = (st_q == B_IDLE);
  assign out_load    = (st_q == B_OUT) && (!out_valid_q || out_ready_i);

  always_comb begin
    case (pidx_q)
      3'd0:    begin pa_c = $signed(cur_q.qx); pb_c = $signed(cur_q.qx); end
      3'd1:    begin pa_c = $signed(cur_q.qy); pb_c = $signed(cur_q.qy); end
      3'd2:    begin pa_c = $signed(cur_q.qz); pb_c = $signed(cur_q.qz); end
      3'd3:    begin pa_c = $signed(cur_q.qw); pb_c = $signed(cur_q.qw); end
      3'd4:    begin pa_c = $signed(cur_q.qx); pb_c = $signed(cur_q.qz); end
      3'd5:    begin pa_c = $signed(cur_q.qw); pb_c = $signed(cur_q.qy); end
      3'd6:    begin pa_c = $signed(cur_q.qx); pb_c = $signed(cur_q.qy); end
      default: begin pa_c = $signed(cur_q.qw); pb_c = $signed(cur_q.qz); end
    endcase
    rhs_c = 54'(norm_q) * 54'sd99999;
    glo_c = (norm_q > 0) && (lhs_q <= -rhs_c);
    ghi_c = (norm_q > 0) && (lhs_q >= rhs_c);

    // cordic operands per phase
    cord_start = 1'b0;
    cord_x     = CORD_W'(gx_q);
    cord_y     = CORD_W'(gy_q);
    if (st_q == B_GHI) begin
      cord_start = 1'b1;
      if (glo_c) begin
        cord_x = -CORD_W'($signed(cur_q.qy));
        cord_y = CORD_W'($signed(cur_q.qx));
      end else if (ghi_c) begin
        cord_x = CORD_W'($signed(cur_q.qy));
        cord_y = -CORD_W'($signed(cur_q.qx));
      end
    end else if (st_q == B_SQX) begin
      cord_start = 1'b1;
      cord_x     = CORD_W'(dx_q);
      cord_y     = CORD_W'(dy_q);
    end

    // binary angle to degrees, rounded and wrapped once
    dsum_c  = {1'b0, dmul_q} + RND;
    dsh_c   = (DW+1)'(dsum_c >> SH);
    deg_w_c = (dsh_c >= FC) ? dsh_c - FC : dsh_c;
    deg_c   = deg_w_c[DW-1:0];

    ux_c = dx_q[32] ? 32'(-dx_q) : dx_q[31:0];
    uy_c = dy_q[32] ? 32'(-dy_q) : dy_q[31:0];

    rem_sh_c = {rem_q[33:0], rad_q[65:64]};
    trial_c  = {1'b0, root_q[32:0], 2'b01};

    bsum_c = {1'b0, atd_q} + FC - {1'b0, fyaw_q};
    hsum_c = {1'b0, fyaw_q} + FC - {1'b0, syaw_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= B_IDLE;
      pidx_q      <= '0;
      sq_cnt_q    <= '0;
      out_valid_q <= 1'b0;
      fx_q <= '0; fy_q <= '0; fst_q <= '0; fyaw_q <= '0;
      sx_q <= '0; sy_q <= '0; sst_q <= '0; syaw_q <= '0;
    end else begin
      if (out_load)                     out_valid_q <= 1'b1;
      else if (out_ready_i)             out_valid_q <= 1'b0;
      case (st_q)
        B_IDLE: if (req_valid_i) begin
          st_q   <= B_PROD;
          pidx_q <= '0;
        end
        B_PROD: begin
          pidx_q <= pidx_q + 3'd1;
          if (pidx_q == 3'd7) st_q <= B_SUM;
        end
        B_SUM:   st_q <= B_GLO;
        B_GLO:   st_q <= B_GHI;
        B_GHI:   st_q <= B_YWAIT;
        B_YWAIT: if (!cord_busy) st_q <= B_YMUL;
        B_YMUL:  st_q <= B_YWRAP;
        B_YWRAP: begin
          st_q <= B_DIFF;
          if (!cur_q.sel) begin
            fx_q <= cur_q.pos_x; fy_q <= cur_q.pos_y;
            fst_q <= cur_q.stamp; fyaw_q <= yaw_q;
          end else begin
            sx_q <= cur_q.pos_x; sy_q <= cur_q.pos_y;
            sst_q <= cur_q.stamp; syaw_q <= yaw_q;
          end
        end
        B_DIFF:  st_q <= (fst_q == '0 || sst_q == '0) ? B_IDLE : B_SQX;
        B_SQX:   st_q <= B_SQY;
        B_SQY: begin
          st_q     <= B_RWAIT;
          sq_cnt_q <= 6'd33;
        end
        B_RWAIT: begin
          if (sq_cnt_q != '0) sq_cnt_q <= sq_cnt_q - 6'd1;
          else if (!cord_busy) st_q <= B_BMUL;
        end
        B_BMUL:  st_q <= B_OUT;
        B_OUT:   if (out_load) st_q <= B_IDLE;
        default: st_q <= B_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (st_q)
      B_IDLE:  cur_q <= req_i;
      B_PROD:  prod_q[pidx_q] <= pa_c * pb_c;
      B_SUM: begin
        norm_q <= 36'(prod_q[0]) + 36'(prod_q[1]) + 36'(prod_q[2]) + 36'(prod_q[3]);
        num_q  <= -(36'(prod_q[4]) - 36'(prod_q[5])) <<< 1;
        gx_q   <= 36'(prod_q[3]) + 36'(prod_q[0]) - 36'(prod_q[1]) - 36'(prod_q[2]);
        gy_q   <= (36'(prod_q[6]) + 36'(prod_q[7])) <<< 1;
      end
      B_GLO:   lhs_q <= 54'(num_q) * 54'sd100000;
      B_GHI:   gimb_q <= glo_c || ghi_c;
      B_YWAIT: dmul_q <= {9'd0, (gimb_q ? {cord_turn[30:0], 1'b0} : cord_turn)} * 41'd360;
      B_YMUL:  yaw_q <= deg_c;
      B_DIFF: begin
        dx_q <= {sx_q[31], sx_q} - {fx_q[31], fx_q};
        dy_q <= {sy_q[31], sy_q} - {fy_q[31], fy_q};
      end
      B_SQX:   acc_q <= 65'({32'd0, ux_c} * {32'd0, ux_c});
      B_SQY: begin
        rad_q  <= {1'b0, acc_q + 65'({32'd0, uy_c} * {32'd0, uy_c})};
        rem_q  <= '0;
        root_q <= '0;
      end
      B_RWAIT: begin
        if (sq_cnt_q != '0) begin
          rad_q <= rad_q << 2;
          if (rem_sh_c >= trial_c) begin
            rem_q  <= rem_sh_c - trial_c;
            root_q <= {root_q[32:0], 1'b1};
          end else begin
            rem_q  <= rem_sh_c;
            root_q <= {root_q[32:0], 1'b0};
          end
        end else if (!cord_busy) begin
          // round once, on the step that leaves for the bearing scale
          if (rem_q > {2'b00, root_q}) root_q <= root_q + 34'd1;
          dmul_q <= {9'd0, cord_turn} * 41'd360;
        end
      end
      B_BMUL:  atd_q <= deg_c;
      B_OUT: if (out_load) begin
        range_q  <= root_q[32:0];
        bear_q   <= (bsum_c >= FC) ? DW'(bsum_c - FC) : DW'(bsum_c);
        hdiff_q  <= (hsum_c >= FC) ? DW'(hsum_c - FC) : DW'(hsum_c);
        ostamp_q <= fst_q;
      end
      default: ;
    endcase
  end

  assign out_valid_o    = out_valid_q;
  assign range_out_o    = range_q;
  assign bearing_out_o  = 25'(bear_q);
  assign heading_diff_o = 25'(hdiff_q);
  assign stamp_out_o    = ostamp_q;

`ifndef SYNTHESIS
  a_yaw_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ({1'b0, fyaw_q} < FC) && ({1'b0, syaw_q} < FC))
    else $error("stored yaw out of range");
  a_out_from_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(st_q == B_OUT))
    else $error("result raised outside output step");
  a_bear_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> ({1'b0, bear_q} < FC) && ({1'b0, hdiff_q} < FC))
    else $error("angle result not wrapped");
  a_one_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q != B_IDLE) |-> !req_ready_o)
    else $error("request taken while busy");
`endif

endmodule

FILE: rtl/relative_range_bearing_core.sv
// Top level of the relative range/bearing block.
// Depends on rrb_pkg, rrb_queue and rrb_back.
//
// Usage:
//  - Input channel (in_valid_i/in_ready_o) carries one pose request for
//    robot 0 or robot 1: position (Q15.16), quaternion (Q1.14), stamp.
//  - A two-entry queue takes requests while the back end is busy, so the
//    sender only stalls once two requests are waiting.
//  - The back end works on one request at a time: quaternion products,
//    the yaw CORDIC (normalize, 28 iterations, quadrant step), degree
//    scaling, pose store, then squared distance and a 33-step square root
//    that runs beside the bearing CORDIC. Both angles pass through the
//    one shared CORDIC unit.
//  - Requests that leave either stored stamp at zero update the pose and
//    give no result.
//  - Output channel (out_valid_o/out_ready_i) holds range, bearing, yaw
//    difference and robot 0 stamp in a register; a stalled receiver holds
//    the back end at its last step, the queue still fills.
//  - Reset clears both stored poses to zero and empties the queue.
module relative_range_bearing_core #(
  parameter int ANGLE_FRAC_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        robot_select_i,
  input  logic [31:0] pos_x_i,
  input  logic [31:0] pos_y_i,
  input  logic [15:0] quat_x_i,
  input  logic [15:0] quat_y_i,
  input  logic [15:0] quat_z_i,
  input  logic [15:0] quat_w_i,
  input  logic [31:0] time_stamp_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [32:0] range_out_o,
  output logic [24:0] bearing_out_o,
  output logic [24:0] heading_diff_o,
  output logic [31:0] stamp_out_o
);
  import rrb_pkg::*;

  pose_t in_req, q_req;
  logic  q_valid, q_ready;

  always_comb begin
    in_req.sel   = robot_select_i;
    in_req.pos_x = pos_x_i;
    in_req.pos_y = pos_y_i;
    in_req.qx    = quat_x_i;
    in_req.qy    = quat_y_i;
    in_req.qz    = quat_z_i;
    in_req.qw    = quat_w_i;
    in_req.stamp = time_stamp_i;
  end

  // front: request queue
  rrb_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_req),
    .out_valid_o (q_valid),
    .out_ready_i (q_ready),
    .out_data_o  (q_req)
  );

  // back: geometry sequencer
  rrb_back #(
    .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .req_valid_i    (q_valid),
    .req_ready_o    (q_ready),
    .req_i          (q_req),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .range_out_o    (range_out_o),
    .bearing_out_o  (bearing_out_o),
    .heading_diff_o (heading_diff_o),
    .stamp_out_o    (stamp_out_o)
  );

endmodule

FILE: bench/testbench.sv
// Self-checking bench for relative_range_bearing_core: pose requests in, range/bearing out.
// Depends on rrb_pkg and the core RTL; predicts each result from the stored poses.
`timescale 1ns / 1ps

module testbench;
  import rrb_pkg::*;

  localparam logic ROBOT_FIRST  = 1'b0;
  localparam logic ROBOT_SECOND = 1'b1;
  localparam int   FRAC         = 16;
  localparam longint unsigned CIRCLE = 64'd360 << FRAC;
  localparam int   HOLD_CYCLES  = 3000;

  typedef struct {
    logic [32:0] range;
    logic [24:0] bearing;
    logic [24:0] hdiff;
    logic [31:0] stamp;
  } meas_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0, in_ready;
  logic sel = 1'b0;
  logic [31:0] px = '0, py = '0, stmp = '0;
  logic [15:0] qx = '0, qy = '0, qz = '0, qw = '0;
  logic out_valid, out_ready = 1'b0;
  logic [32:0] range_o;
  logic [24:0] bearing_o, hdiff_o;
  logic [31:0] stamp_o;

  pose_t pose_fifo[$];
  pose_t on_wire;
  meas_t meas_fifo[$];
  int    n_sent = 0, n_err = 0;
  bit    rx_hold = 1'b0;

  // predictor copy of the stored poses
  logic [31:0] p0_x, p0_y, p0_stamp, p1_x, p1_y, p1_stamp;
  longint unsigned p0_yaw, p1_yaw;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  relative_range_bearing_core i_dut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_ready_o(in_ready),
    .robot_select_i(sel), .pos_x_i(px), .pos_y_i(py),
    .quat_x_i(qx), .quat_y_i(qy), .quat_z_i(qz), .quat_w_i(qw),
    .time_stamp_i(stmp),
    .out_valid_o(out_valid), .out_ready_i(out_ready),
    .range_out_o(range_o), .bearing_out_o(bearing_o),
    .heading_diff_o(hdiff_o), .stamp_out_o(stamp_o)
  );

  function automatic longint unsigned absval(longint v);
    return v < 0 ? longint'(-v) : v;
  endfunction

  // atan2(y,x) as a binary angle, vectoring CORDIC on normalized operands
  function automatic logic [31:0] binary_angle(longint x, longint y);
    longint unsigned ax, ay, m;
    longint cx, cy, z, nx;
    logic [31:0] q;
    ax = absval(x);
    ay = absval(y);
    z = 0;
    if (ay == 0) q = 32'd0;
    else if (ax == 0) q = QUARTER_TURN;
    else begin
      m = ax > ay ? ax : ay;
      while (m < (64'd1 << 58)) begin
        ax <<= 1; ay <<= 1; m <<= 1;
      end
      cx = ax;
      cy = ay;
      for (int i = 0; i < CORDIC_STEPS; i++) begin
        if (cy >= 0) begin
          nx = cx + (cy >>> i);
          cy = cy - (cx >>> i);
          z += atan_entry(i[4:0]);
        end else begin
          nx = cx - (cy >>> i);
          cy = cy + (cx >>> i);
          z -= atan_entry(i[4:0]);
        end
        cx = nx;
      end
      if (z < 0) z = 0;
      if (z > longint'(QUARTER_TURN)) z = QUARTER_TURN;
      q = z[31:0];
    end
    if (x >= 0 && y >= 0) return q;
    if (x < 0 && y >= 0) return HALF_TURN - q;
    if (x < 0) return HALF_TURN + q;
    return 32'd0 - q;
  endfunction

  function automatic longint unsigned degrees(logic [31:0] t);
    longint unsigned d;
    d = (longint'(t) * 360 + (64'd1 << (31 - FRAC))) >> (32 - FRAC);
    if (d >= CIRCLE) d -= CIRCLE;
    return d;
  endfunction

  function automatic longint unsigned yaw_deg(pose_t p);
    longint x, y, z, w, sx, sy, sz, sw, nrm, num;
    logic [31:0] t;
    x = $signed(p.qx); y = $signed(p.qy); z = $signed(p.qz); w = $signed(p.qw);
    sx = x * x; sy = y * y; sz = z * z; sw = w * w;
    nrm = sx + sy + sz + sw;
    num = -2 * (x * z - w * y);
    // near +-90 deg pitch the yaw comes from x and y alone
    if (nrm > 0 && num * 100000 <= -99999 * nrm) t = binary_angle(-y, x) << 1;
    else if (nrm > 0 && num * 100000 >= 99999 * nrm) t = binary_angle(y, -x) << 1;
    else t = binary_angle(sw + sx - sy - sz, 2 * (x * y + w * z));
    return degrees(t);
  endfunction

  // rounded square root of the 65-bit sum carry:lo
  function automatic longint unsigned rounded_root(longint unsigned carry,
                                                   longint unsigned lo);
    longint unsigned rem, root, trial, pr;
    rem = 0;
    root = 0;
    for (int k = 32; k >= 0; k--) begin
      pr = (2 * k >= 64) ? (carry >> (2 * k - 64)) & 3 : (lo >> (2 * k)) & 3;
      rem = (rem << 2) | pr;
      trial = (root << 2) | 1;
      if (rem >= trial) begin
        rem -= trial;
        root = (root << 1) | 1;
      end else root <<= 1;
    end
    if (rem > root) root++;
    return root;
  endfunction

  task automatic store_and_measure(pose_t p);
    longint unsigned yaw, ux, uy, sqx, sqy, lo, atd;
    longint dx, dy;
    meas_t m;
    yaw = yaw_deg(p);
    if (p.sel == ROBOT_FIRST) begin
      p0_x = p.pos_x; p0_y = p.pos_y; p0_yaw = yaw; p0_stamp = p.stamp;
    end else begin
      p1_x = p.pos_x; p1_y = p.pos_y; p1_yaw = yaw; p1_stamp = p.stamp;
    end
    if (p0_stamp == 0 || p1_stamp == 0) return;
    dx = longint'($signed(p1_x)) - longint'($signed(p0_x));
    dy = longint'($signed(p1_y)) - longint'($signed(p0_y));
    ux = absval(dx);
    uy = absval(dy);
    sqx = ux * ux;
    sqy = uy * uy;
    lo = sqx + sqy;
    atd = degrees(binary_angle(dx, dy));
    m.range   = 33'(rounded_root(lo < sqx ? 1 : 0, lo));
    m.bearing = 25'((atd + CIRCLE - p0_yaw) % CIRCLE);
    m.hdiff   = 25'((p0_yaw + CIRCLE - p1_yaw) % CIRCLE);
    m.stamp   = p0_stamp;
    meas_fifo.push_back(m);
  endtask

  // idling phases follow the number of requests sent:
  // none, sender idles, receiver stalls, both
  function automatic bit roll_idle(bit sender);
    int ph;
    ph = (n_sent / 90) % 4;
    if (ph == 0) return 1'b0;
    if (ph == 3) return $urandom_range(0, 99) < 18;
    if (sender) return ph == 1 && $urandom_range(0, 99) < 47;
    return ph == 2 && $urandom_range(0, 99) < 47;
  endfunction

  // sender
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) begin
        store_and_measure(on_wire);
        n_sent++;
      end
      if (!in_valid || in_ready) begin
        if (pose_fifo.size() > 0 && !roll_idle(1'b1)) begin
          on_wire = pose_fifo.pop_front();
          in_valid <= 1'b1;
          sel <= on_wire.sel; px <= on_wire.pos_x; py <= on_wire.pos_y;
          qx <= on_wire.qx; qy <= on_wire.qy; qz <= on_wire.qz; qw <= on_wire.qw;
          stmp <= on_wire.stamp;
        end else in_valid <= 1'b0;
      end
    end
  end

  // receiver and checker
  always @(posedge clk) begin
    meas_t e;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (meas_fifo.size() == 0) begin
          if (n_err < 10) $display("unexpected result: range %0h stamp %0h", range_o, stamp_o);
          n_err++;
        end else begin
          e = meas_fifo.pop_front();
          if (e.range !== range_o || e.bearing !== bearing_o ||
              e.hdiff !== hdiff_o || e.stamp !== stamp_o) begin
            if (n_err < 10)
              $display("mismatch: exp r=%0h b=%0h h=%0h s=%0h got r=%0h b=%0h h=%0h s=%0h",
                       e.range, e.bearing, e.hdiff, e.stamp,
                       range_o, bearing_o, hdiff_o, stamp_o);
            n_err++;
          end
        end
      end
      out_ready <= !rx_hold && !roll_idle(1'b0);
    end
  end

  // long receiver hold-off so the queue fills and the input stalls
  initial begin
    wait (n_sent >= 200);
    @(posedge clk);
    rx_hold = 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    rx_hold = 1'b0;
  end

  function automatic pose_t mk(logic s, logic [31:0] x, logic [31:0] y,
                               logic [15:0] a, logic [15:0] b, logic [15:0] c,
                               logic [15:0] d, logic [31:0] st);
    pose_t p;
    p.sel = s; p.pos_x = x; p.pos_y = y;
    p.qx = a; p.qy = b; p.qz = c; p.qw = d; p.stamp = st;
    return p;
  endfunction

  function automatic logic [15:0] rand_quat();
    int r;
    r = $urandom_range(0, 99);
    if (r < 75) return 16'($urandom_range(0, 32768) - 16384);
    if (r < 90) return 16'($urandom);
    return 16'($urandom_range(0, 6) - 3);
  endfunction

  initial begin
    pose_t p;
    logic [15:0] h;
    logic [31:0] bx, by;
    p0_x = 0; p0_y = 0; p0_stamp = 0; p0_yaw = 0;
    p1_x = 0; p1_y = 0; p1_stamp = 0; p1_yaw = 0;
    h = 16'sd11585;  // 1/sqrt(2) in Q1.14

    // stamps not valid yet: poses stored, nothing reported until both are set
    pose_fifo.push_back(mk(ROBOT_FIRST, 32'h0001_0000, 32'h0, 0, 0, 0, 16'sd16384, 0));
    pose_fifo.push_back(mk(ROBOT_SECOND, 32'h0003_0000, 32'h0004_0000, 0, 0, 0, 16'sd16384, 5));
    pose_fifo.push_back(mk(ROBOT_FIRST, 32'h0, 32'h0, 0, 0, 16'sd16384, 0, 1));
    // position extremes, bearings in the first quadrant, along +y and in the second
    pose_fifo.push_back(mk(ROBOT_FIRST, 32'h8000_0000, 32'h8000_0000, 0, 0, 0, 16'sd16384,
                           32'hFFFF_FFFF));
    pose_fifo.push_back(mk(ROBOT_SECOND, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 0, 0, -16'sd16384, 7));
    pose_fifo.push_back(mk(ROBOT_FIRST, 32'h7FFF_FFFF, 32'h8000_0000, -16'sd16384, 0, 0, 0, 9));
    pose_fifo.push_back(mk(ROBOT_SECOND, 32'h8000_0000, 32'h7FFF_FFFF, 0, -16'sd16384, 0, 0, 3));
    // same position: zero vector
    pose_fifo.push_back(mk(ROBOT_SECOND, 32'h7FFF_FFFF, 32'h8000_0000, 0, 0, 0, 16'sd16384, 4));
    // zero quaternion
    pose_fifo.push_back(mk(ROBOT_FIRST, 32'h1234_5678, 32'hFEDC_BA98, 0, 0, 0, 0, 11));
    // gimbal lock both ways, then just short of it
    pose_fifo.push_back(mk(ROBOT_SECOND, 32'h0, 32'h0, 0, h, 0, h, 12));
    pose_fifo.push_back(mk(ROBOT_FIRST, 32'h10, 32'h20, 0, -h, 0, h, 13));
    pose_fifo.push_back(mk(ROBOT_SECOND, 32'h0, 32'h0, 16'sd3000, h, 0, h, 14));
    pose_fifo.push_back(mk(ROBOT_FIRST, 32'h0, 32'h0, 16'sd2000, -h, 16'sd900, h, 15));
    // out-of-range codes
    pose_fifo.push_back(mk(ROBOT_SECOND, 32'hFFFF_FFFF, 32'h1, 16'h8000, 16'h7FFF, 16'h8000,
                           16'h7FFF, 16));
    pose_fifo.push_back(mk(ROBOT_FIRST, 32'h1, 32'hFFFF_FFFF, 16'hFFFF, 16'h0001, 16'h7FFF,
                           16'h8000, 17));
    // yaw just around the wrap
    pose_fifo.push_back(mk(ROBOT_SECOND, 32'h5, 32'h0, 0, 0, 16'hFFFF, 16'sd16384, 18));
    // stamp back to zero stops results again
    pose_fifo.push_back(mk(ROBOT_SECOND, 32'h5, 32'h6, 0, 0, 0, 16'sd16384, 0));
    pose_fifo.push_back(mk(ROBOT_FIRST, 32'h5, 32'h6, 0, 0, 0, 16'sd16384, 19));
    pose_fifo.push_back(mk(ROBOT_SECOND, 32'h0, 32'hFFFF_0000, 0, 0, 0, 16'sd16384, 20));

    // random part: mostly valid stamps, positions either local or anywhere
    bx = $urandom;
    by = $urandom;
    for (int n = 0; n < 650; n++) begin
      p.sel = 1'($urandom_range(0, 1));
      if ($urandom_range(0, 3) == 0) begin
        p.pos_x = $urandom;
        p.pos_y = $urandom;
      end else begin
        p.pos_x = bx + 32'($urandom_range(0, 1 << 22)) - (1 << 21);
        p.pos_y = by + 32'($urandom_range(0, 1 << 22)) - (1 << 21);
      end
      p.qx = rand_quat(); p.qy = rand_quat(); p.qz = rand_quat(); p.qw = rand_quat();
      if ($urandom_range(0, 9) == 0) begin
        p.qx = 16'($urandom_range(0, 400) - 200);
        p.qz = 0;
        p.qw = h;
        p.qy = $urandom_range(0, 1) ? h : -h;
      end
      p.stamp = ($urandom_range(0, 12) == 0) ? 32'd0 : $urandom;
      pose_fifo.push_back(p);
    end

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    wait (pose_fifo.size() == 0 && !in_valid && meas_fifo.size() == 0);
    repeat (400) @(posedge clk);
    if (n_err == 0 && meas_fifo.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #60_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
